/* sv/nearest_box_selector_defines.svh */
// ----------------------------------------------------------------------------
// nearest_box_selector assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NEAREST_BOX_SELECTOR_DEFINES_SVH
`define NEAREST_BOX_SELECTOR_DEFINES_SVH

// Same-cycle implication.
`define NBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define NBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/nbs_pkg.sv */
// ----------------------------------------------------------------------------
// nbs_pkg
// Widths, register indexes and shared types of the nearest box selector.
// ----------------------------------------------------------------------------
package nbs_pkg;

    localparam int COORD_BITS = 12;
    localparam int CTR_BITS   = COORD_BITS + 1;     // coordinate plus half size
    localparam int SQ_BITS    = 2 * CTR_BITS;       // one squared axis distance
    localparam int DIST_BITS  = SQ_BITS + 1;        // sum of two squares
    localparam int AREA_BITS  = 2 * COORD_BITS;
    localparam int R2_BITS    = AREA_BITS + 1;      // twice the reference area
    localparam int LOWB_BITS  = AREA_BITS + 4;      // 9 * (area + 1)
    localparam int HIGH_BITS  = AREA_BITS + 2;      // 4 * reference area
    localparam int BOX_BITS   = 4 * COORD_BITS;

    localparam int LOW_DIV    = 9;                  // lower bound is R / LOW_DIV
    localparam int HIGH_SHIFT = 2;                  // upper bound is R << HIGH_SHIFT

    localparam int CNT_BITS   = 2;
    localparam int CNT_SAT    = 2;                  // survivor count saturation

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    localparam int CFG_ADDR_BITS = 3;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_MODE       = 3'd0,
        REG_FILTER     = 3'd1,
        REG_REF_X      = 3'd2,
        REG_REF_Y      = 3'd3,
        REG_TRACK_SIZE = 3'd4,
        REG_REF_W      = 3'd5,
        REG_REF_H      = 3'd6
    } nbs_reg_idx_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
    } nbs_box_t;

    typedef struct packed {
        logic                  ref_mode;
        logic                  filter_enable;
        logic [COORD_BITS-1:0] ref_x;
        logic [COORD_BITS-1:0] ref_y;
        logic [COORD_BITS-1:0] track_size;
        logic [COORD_BITS-1:0] ref_w;
        logic [COORD_BITS-1:0] ref_h;
    } nbs_cfg_t;

    // One classified box as it waits between front and back.
    typedef struct packed {
        logic               last;
        logic               keep;
        logic [SQ_BITS-1:0] sq_x;
        logic [SQ_BITS-1:0] sq_y;
        logic [R2_BITS-1:0] r2;
        nbs_box_t           box;
    } nbs_item_t;

endpackage

/* sv/nbs_front.sv */
// ----------------------------------------------------------------------------
// nbs_front
// Two-stage classifier: area filter and squared center distance per box.
// ----------------------------------------------------------------------------
module nbs_front
    import nbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  nbs_cfg_t              cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  nbs_box_t              in_box,
    input  logic                  in_last,
    input  logic [Q_CNT_BITS-1:0] q_level,
    output logic                  q_push,
    output nbs_item_t             q_item
);

    logic                  s1_valid_reg, s1_valid_next;
    nbs_box_t              s1_box_reg, s1_box_next;
    logic                  s1_last_reg, s1_last_next;
    logic                  s1_filter_reg, s1_filter_next;
    logic [AREA_BITS-1:0]  s1_area_reg, s1_area_next;
    logic [AREA_BITS-1:0]  s1_r_reg, s1_r_next;
    logic [CTR_BITS-1:0]   s1_dx_reg, s1_dx_next;
    logic [CTR_BITS-1:0]   s1_dy_reg, s1_dy_next;

    logic                  s2_valid_reg, s2_valid_next;
    nbs_item_t             s2_item_reg, s2_item_next;

    logic                  accept;
    logic [CTR_BITS-1:0]   rx, ry, cx, cy;
    logic [COORD_BITS-1:0] ra, rb;
    logic [LOWB_BITS-1:0]  low_bound;
    logic                  low_fail, high_fail;
    logic [Q_CNT_BITS+1:0] in_flight;

    // Credit check: every box in the pipe already owns a queue slot.
    always_comb
    begin
        in_flight = (Q_CNT_BITS+2)'(q_level) + (Q_CNT_BITS+2)'(s1_valid_reg)
                  + (Q_CNT_BITS+2)'(s2_valid_reg);
        in_ready  = (in_flight <= (Q_CNT_BITS+2)'(Q_DEPTH - 1));
        accept    = in_valid && in_ready;
    end

    // Stage 1: areas and absolute center offsets.
    always_comb
    begin
        rx = cfg.ref_mode ? ({1'b0, cfg.ref_x} + {2'b00, cfg.ref_w[COORD_BITS-1:1]})
                          : {1'b0, cfg.ref_x};
        ry = cfg.ref_mode ? ({1'b0, cfg.ref_y} + {2'b00, cfg.ref_h[COORD_BITS-1:1]})
                          : {1'b0, cfg.ref_y};
        cx = {1'b0, in_box.x} + {2'b00, in_box.w[COORD_BITS-1:1]};
        cy = {1'b0, in_box.y} + {2'b00, in_box.h[COORD_BITS-1:1]};
        ra = cfg.ref_mode ? cfg.ref_w : cfg.track_size;
        rb = cfg.ref_mode ? cfg.ref_h : cfg.track_size;

        s1_valid_next  = accept;
        s1_box_next    = in_box;
        s1_last_next   = in_last;
        s1_filter_next = cfg.filter_enable;
        s1_area_next   = AREA_BITS'(in_box.w) * AREA_BITS'(in_box.h);
        s1_r_next      = AREA_BITS'(ra) * AREA_BITS'(rb);
        s1_dx_next     = (rx >= cx) ? (rx - cx) : (cx - rx);
        s1_dy_next     = (ry >= cy) ? (ry - cy) : (cy - ry);
    end

    // Stage 2: squares and the area window.
    // area < floor(R/9) is the same as 9*(area+1) <= R.
    always_comb
    begin
        low_bound = LOWB_BITS'({s1_area_reg, 3'b000}) + LOWB_BITS'(s1_area_reg)
                  + LOWB_BITS'(LOW_DIV);
        low_fail  = (low_bound <= LOWB_BITS'(s1_r_reg));
        high_fail = (HIGH_BITS'(s1_area_reg) > (HIGH_BITS'(s1_r_reg) << HIGH_SHIFT));

        s2_valid_next     = s1_valid_reg;
        s2_item_next.last = s1_last_reg;
        s2_item_next.keep = !(s1_filter_reg && (low_fail || high_fail));
        s2_item_next.sq_x = SQ_BITS'(s1_dx_reg) * SQ_BITS'(s1_dx_reg);
        s2_item_next.sq_y = SQ_BITS'(s1_dy_reg) * SQ_BITS'(s1_dy_reg);
        s2_item_next.r2   = {s1_r_reg, 1'b0};
        s2_item_next.box  = s1_box_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_box_reg    <= s1_box_next;
        s1_last_reg   <= s1_last_next;
        s1_filter_reg <= s1_filter_next;
        s1_area_reg   <= s1_area_next;
        s1_r_reg      <= s1_r_next;
        s1_dx_reg     <= s1_dx_next;
        s1_dy_reg     <= s1_dy_next;
        s2_item_reg   <= s2_item_next;
    end

    assign q_push = s2_valid_reg;
    assign q_item = s2_item_reg;

endmodule

/* sv/nbs_fifo.sv */
// ----------------------------------------------------------------------------
// nbs_fifo
// Short queue of classified boxes between front and back.
// ----------------------------------------------------------------------------
`include "nearest_box_selector_defines.svh"

module nbs_fifo
    import nbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  nbs_item_t             push_item,
    input  logic                  pop,
    output logic                  pop_valid,
    output nbs_item_t             pop_item,
    output logic [Q_CNT_BITS-1:0] level
);

    nbs_item_t             slot_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_BITS-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_BITS'(push) - Q_CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_valid = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];
    assign level     = count_reg;

    `NBS_ASSERT_NOW(a_no_overflow, push, count_reg != Q_CNT_BITS'(Q_DEPTH), "queue overflow")
    `NBS_ASSERT_NOW(a_no_underflow, pop, count_reg != '0, "pop from empty queue")

endmodule

/* sv/nbs_back.sv */
// ----------------------------------------------------------------------------
// nbs_back
// Running nearest-box tracker and registered result stage.
// ----------------------------------------------------------------------------
`include "nearest_box_selector_defines.svh"

module nbs_back
    import nbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  nbs_item_t q_item,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output logic      out_found,
    output nbs_box_t  out_box
);

    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [DIST_BITS-1:0] min_reg, min_next;
    nbs_box_t             best_reg, best_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg, out_found_next;
    nbs_box_t             out_box_reg, out_box_next;

    logic [DIST_BITS-1:0] cand_dist;
    logic                 take, dist_ok, min_ok, found;
    logic [CNT_BITS-1:0]  count_upd;
    logic [DIST_BITS-1:0] min_upd;
    nbs_box_t             best_upd;

    always_comb
    begin
        // a list end waits only while an unread result occupies the output
        q_pop = q_valid && (!q_item.last || !out_valid_reg || out_ready);

        cand_dist = DIST_BITS'(q_item.sq_x) + DIST_BITS'(q_item.sq_y);
        take      = q_item.keep && (cand_dist <= min_reg);
        dist_ok   = (cand_dist <= DIST_BITS'(q_item.r2));
        min_ok    = (min_reg <= DIST_BITS'(q_item.r2));

        count_upd = (q_item.keep && (count_reg != CNT_BITS'(CNT_SAT)))
                  ? (count_reg + 1'b1) : count_reg;
        min_upd   = take ? cand_dist : min_reg;
        best_upd  = take ? q_item.box : best_reg;
        found     = (count_upd == CNT_BITS'(1))
                 || ((count_upd == CNT_BITS'(CNT_SAT)) && (take ? dist_ok : min_ok));

        count_next     = count_reg;
        min_next       = min_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_found_next = out_found_reg;
        out_box_next   = out_box_reg;

        if (q_pop)
        begin
            if (q_item.last)
            begin
                count_next     = '0;
                min_next       = '1;
                best_next      = '0;
                out_valid_next = 1'b1;
                out_found_next = found;
                out_box_next   = found ? best_upd : '0;
            end
            else
            begin
                count_next = count_upd;
                min_next   = min_upd;
                best_next  = best_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            min_reg       <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            min_reg       <= min_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        out_found_reg <= out_found_next;
        out_box_reg   <= out_box_next;
    end

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_box   = out_box_reg;

    `NBS_ASSERT_NOW(a_empty_when_lost, out_valid_reg && !out_found_reg, out_box_reg == '0, "box not zero without a find")
    `NBS_ASSERT_NEXT(a_list_restart, q_pop && q_item.last, out_valid_reg && (count_reg == '0) && (min_reg == '1), "list state not cleared at list end")

endmodule

/* sv/nearest_box_selector.sv */
// Throughput: one box per cycle unless stalled; two-stage front and tracker both
// take one box each cycle, and a 4-entry queue lets either side stall alone.
// A list end waits only while the previous result has not been taken.
// Reset (rst_n low, asynchronous): control and config registers to defaults, queue and list empty.
// ----------------------------------------------------------------------------
// nearest_box_selector
// Picks, per list of boxes, the filtered box nearest to a reference center.
// ----------------------------------------------------------------------------
module nearest_box_selector
    import nbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    // configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [COORD_BITS-1:0]    cfg_data,

    // box requests
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [BOX_BITS-1:0]      s_tdata,   // cand_x, cand_y, cand_w, cand_h
    input  logic                     s_tlast,   // cand_last

    // selection results, one per list
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [BOX_BITS-1:0]      m_tdata,   // pick_x, pick_y, pick_w, pick_h
    output logic                     m_tuser    // found
);

    nbs_cfg_t              cfg_reg, cfg_next;
    nbs_box_t              in_box;
    logic                  q_push, q_pop, q_valid;
    nbs_item_t             q_in, q_out;
    logic [Q_CNT_BITS-1:0] q_level;
    nbs_box_t              out_box;

    // Register file. The user makes writes only while no list is in flight; the
    // block does not enforce it. The front samples these straight into its pipeline.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_addr)
                REG_MODE:       cfg_next.ref_mode      = cfg_data[0];
                REG_FILTER:     cfg_next.filter_enable = cfg_data[0];
                REG_REF_X:      cfg_next.ref_x         = cfg_data;
                REG_REF_Y:      cfg_next.ref_y         = cfg_data;
                REG_TRACK_SIZE: cfg_next.track_size    = cfg_data;
                REG_REF_W:      cfg_next.ref_w         = cfg_data;
                REG_REF_H:      cfg_next.ref_h         = cfg_data;
                default:        cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ref_mode      <= 1'b0;
            cfg_reg.filter_enable <= 1'b1;
            cfg_reg.ref_x         <= '0;
            cfg_reg.ref_y         <= '0;
            cfg_reg.track_size    <= '0;
            cfg_reg.ref_w         <= '0;
            cfg_reg.ref_h         <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    // unpack request, x in the low bits
    assign in_box.x = s_tdata[COORD_BITS-1:0];
    assign in_box.y = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_box.w = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign in_box.h = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

    nbs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_box   (in_box),
        .in_last  (s_tlast),
        .q_level  (q_level),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    nbs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_out),
        .level     (q_level)
    );

    nbs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_out),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_found (m_tuser),
        .out_box   (out_box)
    );

    // pack result, x in the low bits
    assign m_tdata = {out_box.h, out_box.w, out_box.y, out_box.x};

endmodule

/* tb/sv/nearest_box_selector_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_box_selector_tb
// Self-checking bench: box lists go in on the s_ stream, and each list's pick
// is checked against a local model of the area filter and nearest-center
// choice. A directed plan comes first, then randomized phases under changing
// register settings, with random idling on both streams.
// ----------------------------------------------------------------------------
module nearest_box_selector_tb;
    import nbs_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int PHASES        = 12;
    localparam int STEADY_PHASE  = 5;      // phase run with no idling on either side
    localparam int IDLE_PCT      = 27;
    localparam int NOISE_PCT     = 20;     // boxes with fully random fields
    localparam int SETTLE_CYCLES = 6;      // covers the pipeline after the last pick
    localparam int STALL_LIMIT   = 2000;   // cycles with no handshake at all
    localparam int REPORT_MAX    = 10;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;

    // One expected pick: found flag plus the chosen box (zero when not found).
    typedef struct packed {
        logic     found;
        nbs_box_t box;
    } pick_t;

    typedef enum logic { ROW_WRITE, ROW_BOX } row_kind_t;

    // Directed plan row: either a register write or one box request.
    typedef struct {
        row_kind_t             kind;
        nbs_reg_idx_t          idx;
        logic [COORD_BITS-1:0] value;
        nbs_box_t              box;
        logic                  last;
        logic                  typed;   // pick written into the row by hand
        pick_t                 pick;
    } row_t;

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [COORD_BITS-1:0]    cfg_data  = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [BOX_BITS-1:0]      s_tdata   = '0;   // cand_x, cand_y, cand_w, cand_h
    logic                     s_tlast   = 1'b0; // cand_last
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [BOX_BITS-1:0]      m_tdata;          // pick_x, pick_y, pick_w, pick_h
    logic                     m_tuser;          // found

    nearest_box_selector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Selection model: register copy plus per-list running state
    // ------------------------------------------------------------------------
    nbs_cfg_t              regs;
    logic [CNT_BITS-1:0]   survivors;
    logic [DIST_BITS-1:0]  best_dist;
    nbs_box_t              lead_box;
    pick_t                 pending_picks[$];

    bit                    steady = 1'b0;   // suppresses idling on both streams
    int unsigned           errors = 0;
    int unsigned           boxes_sent = 0;
    int unsigned           lists_done = 0;
    int unsigned           picks_found = 0;
    int unsigned           settings_used = 0;
    int unsigned           quiet = 0;

    function automatic void clear_list();
        survivors = '0;
        best_dist = '1;
        lead_box  = '0;
    endfunction

    // R: track size squared in point mode, reference box area in box mode
    function automatic logic [AREA_BITS-1:0] ref_area();
        if (regs.ref_mode)
            return AREA_BITS'(regs.ref_w) * AREA_BITS'(regs.ref_h);
        return AREA_BITS'(regs.track_size) * AREA_BITS'(regs.track_size);
    endfunction

    function automatic logic [SQ_BITS-1:0] sq_gap(logic [CTR_BITS-1:0] a,
                                                   logic [CTR_BITS-1:0] b);
        logic [CTR_BITS-1:0] d;
        d = (a > b) ? a - b : b - a;
        return SQ_BITS'(d) * SQ_BITS'(d);
    endfunction

    // Fold one accepted box into the running choice; on the list end, queue
    // the pick the block has to produce.
    function automatic void judge_box(nbs_box_t c, logic last);
        logic [AREA_BITS-1:0] r;
        logic [AREA_BITS-1:0] area;
        logic [CTR_BITS-1:0]  cx, cy, rx, ry;
        logic [DIST_BITS-1:0] cand_dist;
        pick_t                p;
        r    = ref_area();
        area = AREA_BITS'(c.w) * AREA_BITS'(c.h);
        if (!regs.filter_enable ||
            (area >= r / LOW_DIV && HIGH_BITS'(area) <= (HIGH_BITS'(r) << HIGH_SHIFT)))
        begin
            cx = CTR_BITS'(c.x) + CTR_BITS'(c.w >> 1);
            cy = CTR_BITS'(c.y) + CTR_BITS'(c.h >> 1);
            rx = CTR_BITS'(regs.ref_x) + (regs.ref_mode ? CTR_BITS'(regs.ref_w >> 1) : '0);
            ry = CTR_BITS'(regs.ref_y) + (regs.ref_mode ? CTR_BITS'(regs.ref_h >> 1) : '0);
            cand_dist = DIST_BITS'(sq_gap(rx, cx)) + DIST_BITS'(sq_gap(ry, cy));
            // ties go to the later box
            if (cand_dist <= best_dist)
            begin
                best_dist = cand_dist;
                lead_box  = c;
            end
            if (survivors < CNT_SAT)
                survivors = survivors + 1'b1;
        end
        if (last)
        begin
            // a lone survivor is taken at any distance; with more, only within 2R
            p.found = (survivors == 2'd1) ||
                      (survivors >= 2'd2 && best_dist <= (R2_BITS'(r) << 1));
            p.box   = p.found ? lead_box : '0;
            pending_picks.push_back(p);
            clear_list();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stream and register drivers; all called at a rising edge
    // ------------------------------------------------------------------------
    task automatic send_box(nbs_box_t c, logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c.h, c.w, c.y, c.x};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        judge_box(c, last);
        boxes_sent++;
    endtask

    // cfg_valid is left high so writes can go back to back; caller drops it
    task automatic write_reg(nbs_reg_idx_t idx, logic [COORD_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MODE:       regs.ref_mode      = value[0];
            REG_FILTER:     regs.filter_enable = value[0];
            REG_REF_X:      regs.ref_x         = value;
            REG_REF_Y:      regs.ref_y         = value;
            REG_TRACK_SIZE: regs.track_size    = value;
            REG_REF_W:      regs.ref_w         = value;
            REG_REF_H:      regs.ref_h         = value;
            default:        ;
        endcase
    endtask

    // Sender holds off until every pick is back, then lets the pipe settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Box generation helpers
    // ------------------------------------------------------------------------
    function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return COORD_BITS'(COORD_MAX);
        return COORD_BITS'(v);
    endfunction

    // extremes one time in five, otherwise 1..hi
    function automatic logic [COORD_BITS-1:0] pick_coord(int unsigned hi);
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return COORD_BITS'(COORD_MAX);
        return COORD_BITS'($urandom_range(1, hi));
    endfunction

    // Box sized around the reference (area near R/9..4R) and centered near
    // the reference center, so the filter edges and the 2R test get hit.
    function automatic nbs_box_t near_box();
        int       sw, sh, cx, cy, w, h, spread;
        nbs_box_t c;
        sw     = int'(regs.ref_mode ? regs.ref_w : regs.track_size);
        sh     = int'(regs.ref_mode ? regs.ref_h : regs.track_size);
        cx     = int'(regs.ref_x) + (regs.ref_mode ? sw / 2 : 0);
        cy     = int'(regs.ref_y) + (regs.ref_mode ? sh / 2 : 0);
        w      = int'($urandom_range(sw / 3, 2 * sw));
        h      = int'($urandom_range(sh / 3, 2 * sh));
        spread = sw + sh + 2;
        c.w = clamp_coord(w);
        c.h = clamp_coord(h);
        c.x = clamp_coord(cx - w / 2 + int'($urandom_range(2 * spread)) - spread);
        c.y = clamp_coord(cy - h / 2 + int'($urandom_range(2 * spread)) - spread);
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Directed plan rows
    // ------------------------------------------------------------------------
    function automatic row_t write_row(nbs_reg_idx_t idx, int unsigned value);
        row_t r;
        r.kind  = ROW_WRITE;
        r.idx   = idx;
        r.value = COORD_BITS'(value);
        r.box   = '0;
        r.last  = 1'b0;
        r.typed = 1'b0;
        r.pick  = '0;
        return r;
    endfunction

    function automatic row_t box_row(int unsigned x, int unsigned y, int unsigned w,
                                     int unsigned h, bit last);
        row_t r;
        r.kind  = ROW_BOX;
        r.idx   = REG_MODE;
        r.value = '0;
        r.box   = {COORD_BITS'(x), COORD_BITS'(y), COORD_BITS'(w), COORD_BITS'(h)};
        r.last  = last;
        r.typed = 1'b0;
        r.pick  = '0;
        return r;
    endfunction

    // List end with a known outcome; when found, the pick is this very box.
    function automatic row_t typed_row(int unsigned x, int unsigned y, int unsigned w,
                                       int unsigned h, bit found);
        row_t r;
        r            = box_row(x, y, w, h, 1'b1);
        r.typed      = 1'b1;
        r.pick.found = found;
        r.pick.box   = found ? r.box : '0;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random backpressure and in-order compare
    // ------------------------------------------------------------------------
    function automatic void compare_field(string name, logic [COORD_BITS-1:0] want,
                                          logic [COORD_BITS-1:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= REPORT_MAX)
                $display("mismatch list %0d %s: expected %0d, got %0d",
                         lists_done, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        pick_t    want;
        nbs_box_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[0 +: COORD_BITS], m_tdata[COORD_BITS +: COORD_BITS],
                   m_tdata[2*COORD_BITS +: COORD_BITS], m_tdata[3*COORD_BITS +: COORD_BITS]};
            if (pending_picks.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected pick: found %0b x %0d y %0d w %0d h %0d",
                             m_tuser, got.x, got.y, got.w, got.h);
            end
            else
            begin
                want = pending_picks.pop_front();
                lists_done++;
                if (want.found)
                    picks_found++;
                compare_field("found", COORD_BITS'(want.found), COORD_BITS'(m_tuser));
                compare_field("pick_x", want.box.x, got.x);
                compare_field("pick_y", want.box.y, got.y);
                compare_field("pick_w", want.box.w, got.w);
                compare_field("pick_h", want.box.h, got.h);
            end
        end
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: ends the run when no handshake of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d picks outstanding",
                     STALL_LIMIT, pending_picks.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        row_t        plan[$];
        bit          writing;
        int unsigned quota, sent_in_phase, list_len;
        nbs_box_t    c;

        // After reset R is zero with the filter on: only zero-area boxes pass.
        plan.push_back(typed_row(0, 0, 0, 0, 1'b1));                 // lone survivor
        plan.push_back(typed_row(4095, 4095, 4095, 4095, 1'b0));     // nothing survives
        plan.push_back(box_row(10, 20, 0, 5, 1'b0));
        plan.push_back(typed_row(4095, 0, 7, 0, 1'b0));              // two, nearest beyond 2R
        plan.push_back(box_row(0, 0, 0, 0, 1'b0));
        plan.push_back(typed_row(0, 0, 1, 0, 1'b1));                 // distance tie, later wins
        // Filter off, point at the far corner, largest track size.
        plan.push_back(write_row(REG_FILTER, 0));
        plan.push_back(write_row(REG_REF_X, 4095));
        plan.push_back(write_row(REG_REF_Y, 4095));
        plan.push_back(write_row(REG_TRACK_SIZE, 4095));
        plan.push_back(typed_row(4095, 4095, 4095, 4095, 1'b1));
        plan.push_back(box_row(0, 0, 0, 0, 1'b0));                   // count saturates
        plan.push_back(box_row(4095, 4095, 0, 0, 1'b0));
        plan.push_back(box_row(100, 100, 10, 10, 1'b1));
        // Box mode with the largest reference: R/9 is exactly 455 * 4095.
        plan.push_back(write_row(REG_MODE, 1));
        plan.push_back(write_row(REG_REF_W, 4095));
        plan.push_back(write_row(REG_REF_H, 4095));
        plan.push_back(write_row(REG_FILTER, 1));
        plan.push_back(typed_row(0, 0, 1, 1, 1'b0));                 // below R/9
        plan.push_back(typed_row(0, 0, 4095, 4095, 1'b1));
        plan.push_back(box_row(0, 0, 454, 4095, 1'b0));              // 4095 short of R/9
        plan.push_back(box_row(4000, 4000, 455, 4095, 1'b0));        // exactly R/9
        plan.push_back(box_row(2047, 2047, 4095, 4095, 1'b1));
        // Tiny reference box: R = 9, so areas 1..36 pass and 2R = 18.
        plan.push_back(write_row(REG_REF_W, 3));
        plan.push_back(write_row(REG_REF_H, 3));
        plan.push_back(typed_row(0, 0, 6, 6, 1'b1));                 // exactly 4R
        plan.push_back(typed_row(0, 0, 37, 1, 1'b0));                // just above 4R
        plan.push_back(box_row(4093, 4093, 6, 6, 1'b0));
        plan.push_back(box_row(4095, 4095, 1, 1, 1'b1));
        plan.push_back(box_row(0, 0, 2, 2, 1'b0));
        plan.push_back(typed_row(10, 10, 2, 2, 1'b0));               // both far past 2R

        regs = '0;
        regs.filter_enable = 1'b1;
        clear_list();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        writing = 1'b0;
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                // registers only change with the block idle
                if (!writing)
                    drain();
                write_reg(plan[i].idx, plan[i].value);
                writing = 1'b1;
            end
            else
            begin
                if (writing)
                    cfg_valid <= 1'b0;
                writing = 1'b0;
                send_box(plan[i].box, plan[i].last);
                if (plan[i].typed)
                    pending_picks[pending_picks.size() - 1] = plan[i].pick;
            end
        end
        settings_used = 4;

        // Random phases: a fresh register setting each, then short lists.
        quota = RANDOM_ITEMS / PHASES;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            steady = (ph == STEADY_PHASE);
            write_reg(REG_MODE, COORD_BITS'($urandom_range(1)));
            write_reg(REG_FILTER, COORD_BITS'($urandom_range(3) != 0));
            write_reg(REG_REF_X, pick_coord(COORD_MAX));
            write_reg(REG_REF_Y, pick_coord(COORD_MAX));
            write_reg(REG_TRACK_SIZE, pick_coord($urandom_range(1) ? 64 : COORD_MAX));
            write_reg(REG_REF_W, pick_coord($urandom_range(1) ? 64 : COORD_MAX));
            write_reg(REG_REF_H, pick_coord($urandom_range(1) ? 64 : COORD_MAX));
            cfg_valid <= 1'b0;
            settings_used++;
            sent_in_phase = 0;
            while (sent_in_phase < quota)
            begin
                list_len = ($urandom_range(9) == 0) ? $urandom_range(5, 12)
                                                    : $urandom_range(1, 4);
                for (int k = 1; k <= list_len; k++)
                begin
                    if ($urandom_range(99) < NOISE_PCT)
                        c = BOX_BITS'({$urandom(), $urandom()});
                    else
                        c = near_box();
                    send_box(c, k == list_len);
                end
                sent_in_phase += list_len;
            end
        end
        steady = 1'b0;
        drain();

        $display("run: %0d boxes in %0d lists under %0d register settings",
                 boxes_sent, lists_done, settings_used);
        $display("run: %0d lists picked a box, %0d picked none, %0d mismatches",
                 picks_found, lists_done - picks_found, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
